[rtl/sv32ut_pkg.sv]
package sv32ut_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_LEAF
  } state_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_WINDOW   = 3'd1,
    STAT_ROOT_INV = 3'd2,
    STAT_LEAF_INV = 3'd3,
    STAT_NOT_USER = 3'd4,
    STAT_BEYOND   = 3'd5
  } status_e;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_ROOT_PPN  = 2'd0,
    REG_USER_BASE = 2'd1,
    REG_USER_TOP  = 2'd2
  } reg_e;

  localparam int unsigned BIT_V = 0;
  localparam int unsigned BIT_U = 4;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [31:0] waddr;
    logic [31:0] wdata;
    logic [31:0] raddr;
  } mem_req_t;

endpackage

[rtl/sv32ut_store.sv]
module sv32ut_store #(
  parameter int unsigned WORDS = 262144
) (
  input  logic                 clk_i,
  input  sv32ut_pkg::mem_req_t req_i,
  output logic [31:0]          rdata_o
);

  localparam int unsigned AW = $clog2(WORDS);

  logic [31:0] mem_q [WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sv32_user_page_translate_top.sv]
// A write word, or a translation failing the window or root bound, has its result
// registered at acceptance; root invalid and leaf bound fail return from ST_ROOT,
// a full walk from ST_LEAF. One write per cycle while the output is free; a walk
// takes no new word until done: two dependent reads of the single-read-port store.
// Reset clears the control state and the three registers; the entry store is
// undefined until written and gets no clearing pass.
module sv32_user_page_translate_top #(
  parameter int unsigned STORE_WORDS = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] virt_addr_i,
  input  logic [17:0] word_index_i,
  input  logic [31:0] word_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] page_addr_o,
  output logic [2:0]  status_o
);

  localparam logic [31:0] STORE_LIMIT = 32'(STORE_WORDS);

  logic [7:0]  root_ppn_q;
  logic [31:0] user_base_q, user_top_q;
  sv32ut_pkg::reg_e cfg_sel;
  logic cfg_we;

  sv32ut_pkg::state_e state_q, state_d;
  sv32ut_pkg::mem_req_t req;
  logic [31:0] rdata;
  logic [31:0] va_q;

  logic        out_valid_q;
  logic [31:0] page_addr_q;
  sv32ut_pkg::status_e status_q;

  logic        in_acc, out_free;
  logic        in_window, root_in, w_in, leaf_in;
  logic        root_v, leaf_v, leaf_u;
  logic [31:0] root_idx, widx, leaf_idx, leaf_page;
  logic        res_load;
  logic [31:0] res_addr;
  sv32ut_pkg::status_e res_status;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = sv32ut_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q  <= '0;
      user_base_q <= '0;
      user_top_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_sel)
        sv32ut_pkg::REG_ROOT_PPN:  root_ppn_q  <= pwdata[7:0];
        sv32ut_pkg::REG_USER_BASE: user_base_q <= pwdata;
        sv32ut_pkg::REG_USER_TOP:  user_top_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      sv32ut_pkg::REG_ROOT_PPN:  prdata = {24'd0, root_ppn_q};
      sv32ut_pkg::REG_USER_BASE: prdata = user_base_q;
      sv32ut_pkg::REG_USER_TOP:  prdata = user_top_q;
      default:                   prdata = '0;
    endcase
  end

  sv32ut_store #(
    .WORDS(STORE_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign in_acc    = in_valid_i & in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_window = (virt_addr_i >= user_base_q) && (virt_addr_i < user_top_q);
  assign root_idx  = {14'd0, root_ppn_q, virt_addr_i[31:22]};
  assign root_in   = root_idx < STORE_LIMIT;
  assign widx      = {14'd0, word_index_i};
  assign w_in      = widx < STORE_LIMIT;
  assign root_v    = rdata[sv32ut_pkg::BIT_V];
  assign leaf_idx  = {rdata[31:10], va_q[21:12]};
  assign leaf_in   = leaf_idx < STORE_LIMIT;
  assign leaf_v    = rdata[sv32ut_pkg::BIT_V];
  assign leaf_u    = rdata[sv32ut_pkg::BIT_U];
  assign leaf_page = {rdata[29:10], 12'd0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      sv32ut_pkg::ST_IDLE: begin
        if (in_acc && opcode_i == sv32ut_pkg::OP_TRANSLATE && in_window && root_in) begin
          state_d = sv32ut_pkg::ST_ROOT;
        end
      end
      sv32ut_pkg::ST_ROOT: begin
        if (root_v && leaf_in) begin
          state_d = sv32ut_pkg::ST_LEAF;
        end else if (out_free) begin
          state_d = sv32ut_pkg::ST_IDLE;
        end
      end
      sv32ut_pkg::ST_LEAF: begin
        if (out_free) begin
          state_d = sv32ut_pkg::ST_IDLE;
        end
      end
      default: state_d = sv32ut_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    req        = '0;
    res_load   = 1'b0;
    res_addr   = '0;
    res_status = sv32ut_pkg::STAT_OK;
    case (state_q)
      sv32ut_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_acc) begin
          if (opcode_i == sv32ut_pkg::OP_WRITE) begin
            req.we    = w_in;
            req.waddr = widx;
            req.wdata = word_data_i;
            res_load  = 1'b1;
          end else if (!in_window) begin
            res_load   = 1'b1;
            res_status = sv32ut_pkg::STAT_WINDOW;
          end else if (!root_in) begin
            res_load   = 1'b1;
            res_status = sv32ut_pkg::STAT_BEYOND;
          end else begin
            req.re    = 1'b1;
            req.raddr = root_idx;
          end
        end
      end
      sv32ut_pkg::ST_ROOT: begin
        if (!root_v) begin
          res_load   = out_free;
          res_status = sv32ut_pkg::STAT_ROOT_INV;
        end else if (!leaf_in) begin
          res_load   = out_free;
          res_status = sv32ut_pkg::STAT_BEYOND;
        end else begin
          req.re    = 1'b1;
          req.raddr = leaf_idx;
        end
      end
      sv32ut_pkg::ST_LEAF: begin
        res_load = out_free;
        if (!leaf_v) begin
          res_status = sv32ut_pkg::STAT_LEAF_INV;
        end else if (!leaf_u) begin
          res_status = sv32ut_pkg::STAT_NOT_USER;
        end else begin
          res_addr = leaf_page;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sv32ut_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      va_q <= virt_addr_i;
    end
    if (res_load) begin
      page_addr_q <= res_addr;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign page_addr_o = page_addr_q;
  assign status_o    = status_q;

endmodule

[rtl/sv32ut_chk.sv]
module sv32ut_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] page_addr_o,
  input logic [2:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == sv32ut_pkg::OP_WRITE |=>
      out_valid_o && status_o == sv32ut_pkg::STAT_OK && page_addr_o == '0)
    else $error("write word result missing or wrong");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sv32ut_pkg::STAT_OK |-> page_addr_o == '0)
    else $error("failed translation carries an address");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= sv32ut_pkg::STAT_BEYOND)
    else $error("status code out of range");

endmodule

bind sv32_user_page_translate_top sv32ut_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .opcode_i   (opcode_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .page_addr_o(page_addr_o),
  .status_o   (status_o)
);

[tb/sv32ut_checker.sv]
`timescale 1ns / 100ps
module sv32ut_checker #(
  parameter int unsigned STORE_WORDS = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [31:0] virt_addr_i,
  input  logic [17:0] word_index_i,
  input  logic [31:0] word_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] page_addr_i,
  input  logic [2:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0]         page_addr;
    sv32ut_pkg::status_e status;
  } lookup_t;

  logic [31:0] pte_store [STORE_WORDS];
  logic [7:0]  root_page = '0;
  logic [31:0] win_base = '0;
  logic [31:0] win_top = '0;
  lookup_t     expected_q [$];
  int          errors = 0;

  assign fail_count_o = errors;

  function automatic lookup_t predict_lookup(logic [31:0] va);
    logic [39:0] slot;
    logic [31:0] pte;
    lookup_t     res;
    res.page_addr = '0;
    res.status = sv32ut_pkg::STAT_OK;
    if (va < win_base || va >= win_top) begin
      res.status = sv32ut_pkg::STAT_WINDOW;
      return res;
    end
    slot = 40'(root_page) * 1024 + 40'(va[31:22]);
    if (slot >= STORE_WORDS) begin
      res.status = sv32ut_pkg::STAT_BEYOND;
      return res;
    end
    pte = pte_store[slot];
    if (!pte[sv32ut_pkg::BIT_V]) begin
      res.status = sv32ut_pkg::STAT_ROOT_INV;
      return res;
    end
    slot = 40'(pte[31:10]) * 1024 + 40'(va[21:12]);
    if (slot >= STORE_WORDS) begin
      res.status = sv32ut_pkg::STAT_BEYOND;
      return res;
    end
    pte = pte_store[slot];
    if (!pte[sv32ut_pkg::BIT_V]) begin
      res.status = sv32ut_pkg::STAT_LEAF_INV;
      return res;
    end
    if (!pte[sv32ut_pkg::BIT_U]) begin
      res.status = sv32ut_pkg::STAT_NOT_USER;
      return res;
    end
    res.page_addr = {pte[29:10], 12'h000};
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    lookup_t want;
    if (!rst_ni) begin
      root_page = '0;
      win_base = '0;
      win_top = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sv32ut_pkg::reg_e'(paddr[3:2]))
          sv32ut_pkg::REG_ROOT_PPN:  root_page = pwdata[7:0];
          sv32ut_pkg::REG_USER_BASE: win_base = pwdata;
          sv32ut_pkg::REG_USER_TOP:  win_top = pwdata;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: page_addr %h status %0d",
                   $time, page_addr_i, status_i);
        end else begin
          want = expected_q.pop_front();
          if (page_addr_i !== want.page_addr) begin
            errors++;
            $display("%0t: page_addr expected %h, actual %h",
                     $time, want.page_addr, page_addr_i);
          end
          if (status_i !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == sv32ut_pkg::OP_WRITE) begin
          if (word_index_i < STORE_WORDS) pte_store[word_index_i] = word_data_i;
          want.page_addr = '0;
          want.status = sv32ut_pkg::STAT_OK;
        end else begin
          want = predict_lookup(virt_addr_i);
        end
        expected_q.push_back(want);
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned STORE_WORDS = 262144;
  localparam int STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = sv32ut_pkg::OP_WRITE;
  logic [31:0] virt_addr_i = '0;
  logic [17:0] word_index_i = '0;
  logic [31:0] word_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] page_addr_o;
  logic [2:0]  status_o;

  int          fail_count;
  int          pending_words;
  int          words_sent = 0;
  int          idle_cycles = 0;
  int          idle_odds = 5;
  bit          calm = 1'b0;
  logic [7:0]  cur_root = '0;
  logic [31:0] cur_base = '0;
  logic [31:0] cur_top = '0;
  logic [31:0] plan_pte [STORE_WORDS];
  bit          plan_seen [STORE_WORDS];
  logic [31:0] hot_va [16];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sv32_user_page_translate_top #(
    .STORE_WORDS(STORE_WORDS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .virt_addr_i (virt_addr_i),
    .word_index_i(word_index_i),
    .word_data_i (word_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .page_addr_o (page_addr_o),
    .status_o    (status_o)
  );

  sv32ut_checker #(
    .STORE_WORDS(STORE_WORDS)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .opcode_i    (opcode_i),
    .virt_addr_i (virt_addr_i),
    .word_index_i(word_index_i),
    .word_data_i (word_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .page_addr_i (page_addr_o),
    .status_i    (status_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(1, idle_odds) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic push_word(sv32ut_pkg::opcode_e op, logic [31:0] va, logic [17:0] idx,
                           logic [31:0] data);
    if (!calm && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    virt_addr_i <= va;
    word_index_i <= idx;
    word_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic put_pte(logic [17:0] idx, logic [31:0] data);
    plan_pte[idx] = data;
    plan_seen[idx] = 1'b1;
    push_word(sv32ut_pkg::OP_WRITE, $urandom, idx, data);
  endtask

  task automatic send_lookup(logic [31:0] va);
    push_word(sv32ut_pkg::OP_TRANSLATE, va, 18'($urandom), $urandom);
  endtask

  task automatic set_reg(sv32ut_pkg::reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      sv32ut_pkg::REG_ROOT_PPN:  cur_root = value[7:0];
      sv32ut_pkg::REG_USER_BASE: cur_base = value;
      default:                   cur_top = value;
    endcase
  endtask

  // drop valid and drain every outstanding word
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] make_root();
    logic [21:0] ppn;
    logic [9:0]  flags;
    ppn = ($urandom_range(0, 7) == 0) ? 22'($urandom) : 22'($urandom_range(0, 255));
    flags = 10'($urandom);
    flags[sv32ut_pkg::BIT_V] = ($urandom_range(0, 7) != 0);
    return {ppn, flags};
  endfunction

  function automatic logic [31:0] make_leaf();
    logic [9:0] flags;
    flags = 10'($urandom);
    flags[sv32ut_pkg::BIT_V] = ($urandom_range(0, 7) != 0);
    flags[sv32ut_pkg::BIT_U] = ($urandom_range(0, 3) != 0);
    return {22'($urandom), flags};
  endfunction

  function automatic bit in_window(logic [31:0] va);
    return va >= cur_base && va < cur_top;
  endfunction

  function automatic logic [17:0] root_slot(logic [31:0] va);
    return {cur_root, va[31:22]};
  endfunction

  function automatic bit leaf_slot(input logic [31:0] va, output logic [17:0] idx);
    logic [21:0] ppn;
    ppn = plan_pte[root_slot(va)][31:10];
    idx = {ppn[7:0], va[21:12]};
    return ppn < (STORE_WORDS / 1024);
  endfunction

  function automatic logic [31:0] pick_va();
    logic [31:0] va;
    int          roll;
    roll = $urandom_range(0, 15);
    va = $urandom;
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0:       va = cur_base;
        1:       va = cur_base - 1;
        2:       va = cur_top - 1;
        default: va = cur_top;
      endcase
    end else if (roll >= 10) begin
      if (cur_base < cur_top) va = cur_base + ($urandom % (cur_top - cur_base));
      hot_va[$urandom_range(0, 15)] = va;
    end else if (roll >= 3) begin
      va = hot_va[$urandom_range(0, 15)];
      if ($urandom_range(0, 1) == 1) va[21:12] = 10'($urandom);
      va[11:0] = 12'($urandom);
    end
    return va;
  endfunction

  // fill any entry the walk would read before sending the lookup
  task automatic walk(logic [31:0] va);
    logic [17:0] leaf_idx;
    if (in_window(va)) begin
      if (!plan_seen[root_slot(va)]) put_pte(root_slot(va), make_root());
      if (plan_pte[root_slot(va)][sv32ut_pkg::BIT_V] && leaf_slot(va, leaf_idx) &&
          !plan_seen[leaf_idx])
        put_pte(leaf_idx, make_leaf());
    end
    send_lookup(va);
  endtask

  task automatic retouch();
    logic [31:0] va;
    logic [17:0] leaf_idx;
    va = hot_va[$urandom_range(0, 15)];
    if (!in_window(va)) begin
      put_pte(18'($urandom), $urandom);
    end else if ($urandom_range(0, 1) == 0 || !plan_seen[root_slot(va)] ||
                 !plan_pte[root_slot(va)][sv32ut_pkg::BIT_V] || !leaf_slot(va, leaf_idx)) begin
      put_pte(root_slot(va), make_root());
    end else begin
      put_pte(leaf_idx, make_leaf());
    end
  endtask

  initial begin
    int          share;
    int          target;
    int          roll;
    logic [7:0]  root_v;
    logic [31:0] base_v;
    logic [31:0] top_v;
    for (int i = 0; i < 16; i++) hot_va[i] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_lookup(32'h0000_0000);
    settle();
    set_reg(sv32ut_pkg::REG_ROOT_PPN, 32'd255);
    set_reg(sv32ut_pkg::REG_USER_BASE, 32'h0000_0000);
    set_reg(sv32ut_pkg::REG_USER_TOP, 32'hFFFF_FFFF);
    put_pte({8'd255, 10'h3FF}, {22'd7, 10'h001});
    put_pte({8'd7, 10'h3FE}, {22'h3F_FFFF, 10'h011});
    send_lookup(32'hFFFF_E000);
    send_lookup(32'hFFFF_FFFF);
    put_pte({8'd7, 10'h3FD}, {22'd1, 10'h001});
    send_lookup(32'hFFFF_D000);
    put_pte({8'd7, 10'h3FC}, {22'd2, 10'h010});
    send_lookup(32'hFFFF_C123);
    put_pte({8'd255, 10'd0}, 32'h0000_0010);
    send_lookup(32'h0000_0000);
    put_pte({8'd255, 10'd1}, {22'd256, 10'h001});
    send_lookup(32'h0040_0000);
    put_pte({8'd255, 10'd2}, {22'd255, 10'h0CF});
    put_pte(18'h3FFFF, {22'h0ABCD, 10'h0D1});
    send_lookup({10'd2, 10'h3FF, 12'hFFF});
    put_pte({8'd255, 10'd3}, {22'h3F_FFFF, 10'h3FF});
    send_lookup(32'h00C0_0000);
    put_pte(18'h00000, 32'h0000_0000);
    put_pte(18'h3FFFF, 32'hFFFF_FFFF);
    send_lookup({10'd2, 10'h3FF, 12'h000});

    for (int p = 0; p < 6; p++) begin
      settle();
      root_v = 8'($urandom);
      base_v = 32'h0000_0000;
      top_v = 32'hFFFF_FFFF;
      share = 280;
      idle_odds = 5;
      case (p)
        1: begin
          root_v = 8'd0;
          base_v = $urandom & 32'hFFFF_F000;
          top_v = base_v + ($urandom_range(1, 64) << 22);
          idle_odds = 3;
        end
        2: begin
          root_v = 8'hFF;
          base_v = $urandom;
          top_v = $urandom;
        end
        3: begin
          base_v = 32'hFFFF_FFFF;
          top_v = 32'h0000_0000;
          share = 60;
        end
        4: begin
          base_v = 32'h8000_0000;
          idle_odds = 2;
        end
        5: begin
          base_v = $urandom_range(0, 32'h0FFF_FFFF);
          top_v = 32'hFFFF_FFFF - $urandom_range(0, 32'h0FFF_FFFF);
          calm = 1'b1;
        end
        default: ;
      endcase
      set_reg(sv32ut_pkg::REG_ROOT_PPN, {24'h0, root_v});
      set_reg(sv32ut_pkg::REG_USER_BASE, base_v);
      set_reg(sv32ut_pkg::REG_USER_TOP, top_v);
      target = words_sent + share;
      while (words_sent < target) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) put_pte(18'($urandom), $urandom);
        else if (roll == 1) retouch();
        else walk(pick_va());
      end
    end
    settle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sv32_user_page_translate_top.f]
rtl/sv32ut_pkg.sv
rtl/sv32ut_store.sv
rtl/sv32_user_page_translate_top.sv
rtl/sv32ut_chk.sv
tb/sv32ut_checker.sv
tb/tb_top.sv
